// ===== rtl/core/pcorr_pkg.sv =====
// pcorr_pkg: widths, codes, state types and the controller command bundle
// shared by the correlation accumulator controller, datapath and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcorr_pkg;

   // item and configuration widths
   localparam int RATING_WIDTH    = 3;
   localparam int MEAN_WIDTH      = 11;
   localparam int DEV_WIDTH       = 12;
   localparam int CSR_INDEX_WIDTH = 2;

   // per-item product widths
   localparam int CROSS_PROD_WIDTH = 2 * DEV_WIDTH;
   localparam int SQ_PROD_WIDTH    = 23;

   // accumulator widths
   localparam int SUM_WIDTH  = 40;
   localparam int HALF_WIDTH = SUM_WIDTH / 2;
   localparam int MUL_WIDTH  = SUM_WIDTH + HALF_WIDTH;
   localparam int PROD_WIDTH = 2 * SUM_WIDTH;

   // root/divide search widths
   localparam int Q_WIDTH        = 16;
   localparam int Q_TOP          = Q_WIDTH - 1;
   localparam int R_SHIFT        = 32;
   localparam int SEARCH_WIDTH   = 116;
   localparam int BIT_CNT_WIDTH  = 4;
   localparam int COEF_WIDTH     = 16;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEAN_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEAN_SECOND = 2'd1;

   // positive saturation of the coefficient
   localparam logic [COEF_WIDTH-1:0] COEF_POS_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_MUL,
      ST_SEARCH,
      ST_DONE
   } ctrl_state_type;

   // shared multiplier schedule: two partial products for each of a*b and c*c
   typedef enum logic [2:0] {
      MS_AB_LO,
      MS_AB_HI,
      MS_CC_LO,
      MS_CC_HI,
      MS_FINISH
   } mul_step_type;

   // phases of each trial bit of the search
   typedef enum logic [1:0] {
      PH_SUM,
      PH_TRIAL,
      PH_DIFF,
      PH_DECIDE
   } srch_phase_type;

   typedef struct packed {
      logic           capture;
      logic           acc_en;
      logic           mul_en;
      mul_step_type   mul_step;
      logic           srch_init;
      logic           srch_en;
      srch_phase_type srch_phase;
      logic           load_out;
   } pcorr_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/pcorr_ctrl.sv =====
// pcorr_ctrl: state machine that sequences item accumulation, the shared
// multiplier, the bit-by-bit coefficient search and the result register.
// Depends on pcorr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcorr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_contributes,
   input  logic                    req_last_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output pcorr_pkg::pcorr_cmd_type cmd
);

   pcorr_pkg::ctrl_state_type state_ff, state_in;
   pcorr_pkg::mul_step_type   mul_step_ff, mul_step_in;
   pcorr_pkg::srch_phase_type phase_ff, phase_in;
   logic [pcorr_pkg::BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic last_ff, last_in;
   logic contrib_ff, contrib_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic out_free;

   assign accept   = req_valid && (state_ff == pcorr_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcorr_pkg::ST_IDLE: begin
            if (req_valid) state_in = pcorr_pkg::ST_ACC;
         end
         pcorr_pkg::ST_ACC: begin
            state_in = last_ff ? pcorr_pkg::ST_MUL : pcorr_pkg::ST_IDLE;
         end
         pcorr_pkg::ST_MUL: begin
            if (mul_step_ff == pcorr_pkg::MS_FINISH) state_in = pcorr_pkg::ST_SEARCH;
         end
         pcorr_pkg::ST_SEARCH: begin
            if (phase_ff == pcorr_pkg::PH_DECIDE && bit_cnt_ff == '0)
               state_in = pcorr_pkg::ST_DONE;
         end
         pcorr_pkg::ST_DONE: begin
            if (out_free) state_in = pcorr_pkg::ST_IDLE;
         end
         default: state_in = pcorr_pkg::ST_IDLE;
      endcase
   end

   // counters and flags
   always_comb begin
      mul_step_in  = mul_step_ff;
      phase_in     = phase_ff;
      bit_cnt_in   = bit_cnt_ff;
      last_in      = last_ff;
      contrib_in   = contrib_ff;
      rsp_valid_in = rsp_valid_ff;

      if (accept) begin
         last_in    = req_last_item;
         contrib_in = req_contributes;
      end

      if (state_ff == pcorr_pkg::ST_ACC) mul_step_in = pcorr_pkg::MS_AB_LO;

      if (state_ff == pcorr_pkg::ST_MUL) begin
         case (mul_step_ff)
            pcorr_pkg::MS_AB_LO: mul_step_in = pcorr_pkg::MS_AB_HI;
            pcorr_pkg::MS_AB_HI: mul_step_in = pcorr_pkg::MS_CC_LO;
            pcorr_pkg::MS_CC_LO: mul_step_in = pcorr_pkg::MS_CC_HI;
            pcorr_pkg::MS_CC_HI: mul_step_in = pcorr_pkg::MS_FINISH;
            default:             mul_step_in = pcorr_pkg::MS_FINISH;
         endcase
         phase_in   = pcorr_pkg::PH_SUM;
         bit_cnt_in = '1;
      end

      if (state_ff == pcorr_pkg::ST_SEARCH) begin
         case (phase_ff)
            pcorr_pkg::PH_SUM:   phase_in = pcorr_pkg::PH_TRIAL;
            pcorr_pkg::PH_TRIAL: phase_in = pcorr_pkg::PH_DIFF;
            pcorr_pkg::PH_DIFF:  phase_in = pcorr_pkg::PH_DECIDE;
            default: begin
               phase_in   = pcorr_pkg::PH_SUM;
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         endcase
      end

      // result register: taken beat clears, a new result sets
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (state_ff == pcorr_pkg::ST_DONE && out_free) rsp_valid_in = 1'b1;
   end

   // command outputs
   always_comb begin
      cmd            = '0;
      cmd.mul_step   = mul_step_ff;
      cmd.srch_phase = phase_ff;
      cmd.capture    = accept;
      cmd.acc_en     = (state_ff == pcorr_pkg::ST_ACC) && contrib_ff;
      cmd.mul_en     = (state_ff == pcorr_pkg::ST_MUL);
      cmd.srch_init  = (state_ff == pcorr_pkg::ST_MUL) &&
                       (mul_step_ff == pcorr_pkg::MS_FINISH);
      cmd.srch_en    = (state_ff == pcorr_pkg::ST_SEARCH);
      cmd.load_out   = (state_ff == pcorr_pkg::ST_DONE) && out_free;
   end

   assign req_stall = (state_ff != pcorr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcorr_pkg::ST_IDLE;
         mul_step_ff  <= pcorr_pkg::MS_AB_LO;
         phase_ff     <= pcorr_pkg::PH_SUM;
         bit_cnt_ff   <= '0;
         last_ff      <= 1'b0;
         contrib_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_step_ff  <= mul_step_in;
         phase_ff     <= phase_in;
         bit_cnt_ff   <= bit_cnt_in;
         last_ff      <= last_in;
         contrib_ff   <= contrib_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pcorr_datapath.sv =====
// pcorr_datapath: mean registers, deviation products, saturating sums,
// shared 40x20 multiplier and the shift-add search for the coefficient.
// Depends on pcorr_pkg; driven by commands from pcorr_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module pcorr_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pcorr_pkg::pcorr_cmd_type                cmd,
   input  logic                                    csr_write,
   input  logic [pcorr_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pcorr_pkg::MEAN_WIDTH-1:0]        csr_data,
   input  logic [pcorr_pkg::RATING_WIDTH-1:0]      rating_first,
   input  logic [pcorr_pkg::RATING_WIDTH-1:0]      rating_second,
   output logic signed [pcorr_pkg::COEF_WIDTH-1:0] coefficient,
   output logic                                    degenerate
);

   localparam int SW   = pcorr_pkg::SEARCH_WIDTH;
   localparam int SUMW = pcorr_pkg::SUM_WIDTH;
   localparam int CPW  = pcorr_pkg::CROSS_PROD_WIDTH;
   localparam int HW   = pcorr_pkg::HALF_WIDTH;
   localparam int QW   = pcorr_pkg::Q_WIDTH;

   logic [pcorr_pkg::MEAN_WIDTH-1:0] mean_first_ff, mean_second_ff;

   logic signed [pcorr_pkg::DEV_WIDTH-1:0] dev_first, dev_second;
   logic signed [CPW-1:0] cross_full, sq1_full, sq2_full;
   logic [CPW-1:0] cross_prod_ff;
   logic [pcorr_pkg::SQ_PROD_WIDTH-1:0] sq1_prod_ff, sq2_prod_ff;

   logic [SUMW-1:0] sum_cross_ff, sum_sq1_ff, sum_sq2_ff;
   logic [SUMW:0]   cross_ext, sq1_ext, sq2_ext;
   logic [SUMW-1:0] cross_sat, sq1_sat, sq2_sat;

   logic [SUMW-1:0] c_abs;
   logic [SUMW-1:0] mul_a;
   logic [HW-1:0]   mul_b;
   logic [pcorr_pkg::MUL_WIDTH-1:0]  mul_prod_ff;
   logic [pcorr_pkg::PROD_WIDTH-1:0] p_ff, c2_ff;

   logic [SW-1:0] ps1_ff, ps2_ff, pqs_ff, pq_ff, pq2_ff;
   logic [SW-1:0] x_ff, t1_ff, t2_ff, w_ff, v_ff, cand_ff;
   logic [SW-1:0] r_ext;
   logic [QW-1:0] q_ff, mask_ff;
   logic          trial_ok;

   logic signed [pcorr_pkg::COEF_WIDTH-1:0] coef_ff;
   logic                                    deg_ff;
   logic                                    denom_zero;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_first_ff  <= '0;
         mean_second_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == pcorr_pkg::CSR_MEAN_FIRST)  mean_first_ff  <= csr_data;
         if (csr_index == pcorr_pkg::CSR_MEAN_SECOND) mean_second_ff <= csr_data;
      end
   end

   // deviations from the means in signed q3.8 and their products
   assign dev_first  = $signed({1'b0, rating_first, 8'b0}) - $signed({1'b0, mean_first_ff});
   assign dev_second = $signed({1'b0, rating_second, 8'b0}) - $signed({1'b0, mean_second_ff});
   assign cross_full = dev_first * dev_second;
   assign sq1_full   = dev_first * dev_first;
   assign sq2_full   = dev_second * dev_second;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cross_prod_ff <= cross_full;
         sq1_prod_ff   <= sq1_full[pcorr_pkg::SQ_PROD_WIDTH-1:0];
         sq2_prod_ff   <= sq2_full[pcorr_pkg::SQ_PROD_WIDTH-1:0];
      end
   end

   // saturating accumulation
   assign cross_ext = {sum_cross_ff[SUMW-1], sum_cross_ff}
                    + {{(SUMW+1-CPW){cross_prod_ff[CPW-1]}}, cross_prod_ff};
   assign sq1_ext   = {1'b0, sum_sq1_ff} + (SUMW+1)'(sq1_prod_ff);
   assign sq2_ext   = {1'b0, sum_sq2_ff} + (SUMW+1)'(sq2_prod_ff);

   always_comb begin
      cross_sat = cross_ext[SUMW-1:0];
      if (cross_ext[SUMW] != cross_ext[SUMW-1])
         cross_sat = cross_ext[SUMW] ? {1'b1, {(SUMW-1){1'b0}}} : {1'b0, {(SUMW-1){1'b1}}};
      sq1_sat = sq1_ext[SUMW] ? '1 : sq1_ext[SUMW-1:0];
      sq2_sat = sq2_ext[SUMW] ? '1 : sq2_ext[SUMW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_out) begin
         sum_cross_ff <= '0;
         sum_sq1_ff   <= '0;
         sum_sq2_ff   <= '0;
      end else if (cmd.acc_en) begin
         sum_cross_ff <= cross_sat;
         sum_sq1_ff   <= sq1_sat;
         sum_sq2_ff   <= sq2_sat;
      end
   end

   // shared multiplier: a*b and c*c from two half-width partial products each
   assign c_abs = sum_cross_ff[SUMW-1] ? (~sum_cross_ff + 1'b1) : sum_cross_ff;

   always_comb begin
      mul_a = c_abs;
      mul_b = '0;
      case (cmd.mul_step)
         pcorr_pkg::MS_AB_LO: begin
            mul_a = sum_sq1_ff;
            mul_b = sum_sq2_ff[HW-1:0];
         end
         pcorr_pkg::MS_AB_HI: begin
            mul_a = sum_sq1_ff;
            mul_b = sum_sq2_ff[SUMW-1:HW];
         end
         pcorr_pkg::MS_CC_LO: mul_b = c_abs[HW-1:0];
         pcorr_pkg::MS_CC_HI: mul_b = c_abs[SUMW-1:HW];
         default:             mul_b = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         mul_prod_ff <= mul_a * mul_b;
         case (cmd.mul_step)
            pcorr_pkg::MS_AB_HI:  p_ff  <= pcorr_pkg::PROD_WIDTH'(mul_prod_ff);
            pcorr_pkg::MS_CC_LO:  p_ff  <= p_ff + {mul_prod_ff, {HW{1'b0}}};
            pcorr_pkg::MS_CC_HI:  c2_ff <= pcorr_pkg::PROD_WIDTH'(mul_prod_ff);
            pcorr_pkg::MS_FINISH: c2_ff <= c2_ff + {mul_prod_ff, {HW{1'b0}}};
            default: ;
         endcase
      end
   end

   // search for the largest q with (2q-1)^2 * p <= c^2 * 2^32, one bit per
   // pass of the search phases; p*q and p*q^2 are kept up to date by shifts and adds
   assign r_ext    = SW'({c2_ff, {pcorr_pkg::R_SHIFT{1'b0}}});
   assign trial_ok = (v_ff <= r_ext) && !q_ff[QW-1];

   always_ff @(posedge clock) begin
      if (cmd.srch_init) begin
         ps1_ff  <= SW'(p_ff) << pcorr_pkg::Q_TOP;
         ps2_ff  <= SW'(p_ff) << (2 * pcorr_pkg::Q_TOP);
         pqs_ff  <= '0;
         pq_ff   <= '0;
         pq2_ff  <= '0;
         q_ff    <= '0;
         mask_ff <= {1'b1, {(QW-1){1'b0}}};
      end else if (cmd.srch_en) begin
         case (cmd.srch_phase)
            pcorr_pkg::PH_SUM: begin
               x_ff  <= pq2_ff + pqs_ff;
               t1_ff <= pq_ff + ps1_ff;
            end
            pcorr_pkg::PH_TRIAL: begin
               t2_ff <= x_ff + ps2_ff;
               w_ff  <= (t1_ff << 2) - SW'(p_ff);
            end
            pcorr_pkg::PH_DIFF: begin
               v_ff    <= (t2_ff << 2) - w_ff;
               cand_ff <= pqs_ff + (ps2_ff << 1);
            end
            default: begin
               if (trial_ok) begin
                  q_ff   <= q_ff | mask_ff;
                  pq2_ff <= t2_ff;
                  pq_ff  <= t1_ff;
                  pqs_ff <= cand_ff >> 1;
               end else begin
                  pqs_ff <= pqs_ff >> 1;
               end
               ps1_ff  <= ps1_ff >> 1;
               ps2_ff  <= ps2_ff >> 2;
               mask_ff <= mask_ff >> 1;
            end
         endcase
      end
   end

   // result register
   assign denom_zero = (sum_sq1_ff == '0) || (sum_sq2_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         deg_ff <= denom_zero;
         if (denom_zero)
            coef_ff <= '0;
         else if (sum_cross_ff[SUMW-1])
            coef_ff <= $signed(~q_ff + 1'b1);
         else if (q_ff[QW-1])
            coef_ff <= $signed(pcorr_pkg::COEF_POS_MAX);
         else
            coef_ff <= $signed(q_ff);
      end
   end

   assign coefficient = coef_ff;
   assign degenerate  = deg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pearson_correlation_accumulator_core.sv =====
// pearson_correlation_accumulator_core: top level of the rating correlation
// accumulator. Depends on pcorr_pkg, pcorr_ctrl and pcorr_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted beat carries one pair of ratings; the two rater means (Q3.8)
// are subtracted and, if the beat contributes, the cross product and both
// squares are added into saturating 40-bit sums. A beat that does not end
// the run passes through the deviation products, then the add. A beat with
// last_item set goes on from the add to the shared 40x20 multiplier to form
// the two 80-bit products, then to the 16-bit coefficient search (116-bit
// add and compare per bit) and then loads the result register. The result
// register holds a finished coefficient while the next run is already being
// accepted; a second result waits only if the first is still stalled. Mean
// registers are written through the csr port, which is always ready; index
// values other than 0 and 1 are ignored.
module pearson_correlation_accumulator_core (
   input  logic                                    clock,
   input  logic                                    reset,
   // configuration write channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pcorr_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pcorr_pkg::MEAN_WIDTH-1:0]        csr_data,
   // item channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [pcorr_pkg::RATING_WIDTH-1:0]      req_rating_first,
   input  logic [pcorr_pkg::RATING_WIDTH-1:0]      req_rating_second,
   input  logic                                    req_contributes,
   input  logic                                    req_last_item,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [pcorr_pkg::COEF_WIDTH-1:0] rsp_coefficient,
   output logic                                    rsp_degenerate
);

   pcorr_pkg::pcorr_cmd_type cmd;

   assign csr_ready = 1'b1;

   pcorr_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_contributes (req_contributes),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd)
   );

   pcorr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_write     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rating_first  (req_rating_first),
      .rating_second (req_rating_second),
      .coefficient   (rsp_coefficient),
      .degenerate    (rsp_degenerate)
   );

   // loading the result register always raises the result beat
   assert property (@(posedge clock) disable iff (reset) cmd.load_out |=> rsp_valid)
      else $error("result load did not raise rsp_valid");

   // a beat that does not end the run frees the item channel after the capture and add states
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_last_item) |=> ##1 !req_stall)
      else $error("item channel not free after a non-final beat");

   // a zero denominator forces a zero coefficient
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_coefficient == '0))
      else $error("degenerate result with nonzero coefficient");

   // accumulation never overlaps the final multiply, search or result load
   assert property (@(posedge clock) disable iff (reset)
      cmd.acc_en |-> (!cmd.mul_en && !cmd.srch_en && !cmd.load_out))
      else $error("accumulate overlaps result computation");

endmodule

`default_nettype wire
